// ===== rtl/core/arxwg_pkg.sv =====
// Package with the item types, register codes and constants of the add-rotate-xor word generator.
`timescale 1ns / 1ps

package arxwg_pkg;

    // Input transaction: request kind and run length.
    typedef struct packed {
        logic       req_type;
        logic [6:0] draw_count;
    } t_in_item;

    // Output transaction: one generated word and the end-of-run flag.
    typedef struct packed {
        logic [63:0] random_word;
        logic        last_of_run;
    } t_out_item;

    // Request kinds.
    localparam logic REQ_DRAW   = 1'b0;
    localparam logic REQ_RESEED = 1'b1;

    // Register index, taken from paddr[3] (registers lie 8 bytes apart).
    localparam logic REG_SEED = 1'b0;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 64;

    // 11 raised to n, modulo 2^64. Evaluated at elaboration only.
    function automatic logic [63:0] pow11(input int unsigned n);
        logic [63:0] acc;
        acc = 64'd1;
        for (int unsigned i = 0; i < n; i++) begin
            acc = acc * 64'd11;
        end
        return acc;
    endfunction

endpackage

// ===== rtl/core/add_rotate_xor_word_generator.sv =====
// Top level of the add-rotate-xor word generator: APB seed register, item control and word datapath.
`timescale 1ns / 1ps

// Channel     | Direction | Handshake                | Payload
// ------------+-----------+--------------------------+--------------------------------
// in          | input     | i_in_valid / o_in_ready   | i_in_item  (req_type, draw_count)
// out         | output    | o_out_valid / i_out_ready | o_out_item (random_word, last_of_run)
// config APB  | input     | psel / penable / pready   | paddr, pwdata, prdata (seed_value)
//
// A draw transaction of n words (n cut to MAX_RUN) delivers one word per cycle
// while the output is not stalled; the combinational word datapath sets that rate.
// A reseed transaction, or a draw with a count of zero, completes in the cycle it is accepted.
// The next input transaction is accepted in the same cycle as the last word of a run is made,
// so runs follow each other without a gap. A stalled output register holds the generator still.
// Reset is synchronous and active low; it clears the generator as if seeded with zero and needs
// no clearing pass.
module add_rotate_xor_word_generator #(
    parameter int unsigned WORD_BITS = 64,
    parameter int unsigned MAX_RUN   = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input transaction channel.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  arxwg_pkg::t_in_item                 i_in_item,
    // Output transaction channel.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output arxwg_pkg::t_out_item                o_out_item,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [arxwg_pkg::PADDR_W-1:0]       paddr,
    input  logic [arxwg_pkg::PDATA_W-1:0]       pwdata,
    output logic [arxwg_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);
    import arxwg_pkg::*;

    // Shift and rotate amounts, all strictly between zero and WORD_BITS for WORD_BITS >= 8.
    localparam int unsigned SH_XR    = WORD_BITS / 4;
    localparam int unsigned SH_XL    = WORD_BITS - SH_XR;
    localparam int unsigned SH_YL    = (WORD_BITS / 2) - 1;
    localparam int unsigned SH_YR    = WORD_BITS - SH_YL;
    localparam int unsigned SH_ZL    = 1;
    localparam int unsigned SH_ZR    = WORD_BITS - SH_ZL;
    localparam int unsigned ROT_GL   = (WORD_BITS - 3) / 2;
    localparam int unsigned ROT_GR   = (WORD_BITS - 5) / 3;
    localparam int unsigned WEYL_EXP = (2 * WORD_BITS) / 7;
    localparam int unsigned LEFT_W   = $clog2(MAX_RUN + 1);

    localparam logic [63:0]          WEYL_INC_64 = pow11(WEYL_EXP);
    localparam logic [WORD_BITS-1:0] WEYL_INC    = WEYL_INC_64[WORD_BITS-1:0];
    localparam logic [6:0]           MAX_RUN_7   = 7'(MAX_RUN);

    // ------------------------------------------------------------------
    // Configuration register. pready is tied high, so every access has
    // no wait states.
    // ------------------------------------------------------------------
    logic [63:0] r_seed;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[3] == REG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (cfg_wr) begin
            r_seed <= pwdata;
        end
    end

    always_comb begin
        if (paddr[3] == REG_SEED) begin
            prdata = r_seed;
        end else begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Generator state. r_wnext holds the Weyl counter value that the next
    // word will use (the counter already advanced by one step), which keeps
    // the counter add off the word path.
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0] r_wnext, n_wnext;
    logic [WORD_BITS-1:0] r_mix [4];
    logic [WORD_BITS-1:0] n_mix [4];

    // Run control: a run is in progress while r_busy is set, with r_left words still to make.
    logic              r_busy, n_busy;
    logic [LEFT_W-1:0] r_left, n_left;

    // Output register.
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item,  n_out_item;

    logic                 advance;
    logic                 last_word;
    logic                 in_fire;
    logic [6:0]           run_len;
    logic [WORD_BITS-1:0] seed_w;
    logic [WORD_BITS-1:0] g_word, x_word, y_word, z_word, u_word, t_word, res_word;

    // A word is made whenever a run is active and the output register is free or being emptied.
    assign advance    = r_busy && (!r_out_valid || i_out_ready);
    assign last_word  = (r_left == LEFT_W'(1));
    assign o_in_ready = !r_busy || (advance && last_word);
    assign in_fire    = i_in_valid && o_in_ready;
    assign seed_w     = r_seed[WORD_BITS-1:0];
    assign run_len    = (i_in_item.draw_count > MAX_RUN_7) ? MAX_RUN_7 : i_in_item.draw_count;

    // Word datapath: two rotations of the counter, three funnel shifts of the mixing words.
    always_comb begin
        g_word   = ((r_wnext << ROT_GL) | (r_wnext >> (WORD_BITS - ROT_GL)))
                 + ((r_wnext >> ROT_GR) | (r_wnext << (WORD_BITS - ROT_GR)))
                 + WEYL_INC;
        x_word   = (r_mix[3] << SH_XL) | (r_mix[2] >> SH_XR);
        y_word   = (r_mix[2] << SH_YL) | (r_mix[1] >> SH_YR);
        z_word   = (r_mix[1] << SH_ZL) | (r_mix[3] >> SH_ZR);
        u_word   = x_word + y_word + z_word;
        t_word   = ~((r_mix[0] ^ g_word) ^ u_word);
        res_word = t_word + r_wnext;
    end

    // Next-state logic. A word for the current run is made before a newly accepted
    // transaction takes effect, so a reseed in the same cycle overrides the update.
    always_comb begin
        n_wnext     = r_wnext;
        n_mix       = r_mix;
        n_busy      = r_busy;
        n_left      = r_left;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;

        if (advance) begin
            n_wnext                = r_wnext + WEYL_INC;
            n_mix[0]               = r_mix[1];
            n_mix[1]               = r_mix[1] ^ r_mix[2];
            n_mix[2]               = r_mix[3];
            n_mix[3]               = r_mix[3] ^ t_word;
            n_out_valid            = 1'b1;
            n_out_item.random_word = 64'(res_word);
            n_out_item.last_of_run = last_word;
            n_left                 = r_left - LEFT_W'(1);
            n_busy                 = !last_word;
        end

        if (in_fire) begin
            if (i_in_item.req_type == REQ_RESEED) begin
                n_wnext = seed_w + WEYL_INC;
                for (int i = 0; i < 4; i++) begin
                    n_mix[i] = seed_w;
                end
            end else if (run_len != 7'd0) begin
                n_busy = 1'b1;
                n_left = run_len[LEFT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wnext     <= WEYL_INC;
            for (int i = 0; i < 4; i++) begin
                r_mix[i] <= '0;
            end
            r_busy      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wnext     <= n_wnext;
            r_mix       <= n_mix;
            r_busy      <= n_busy;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An active run always has words left.
    a_busy_has_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0))
        else $error("run active with no words left");

    // A new transaction overlaps a run only in the cycle its last word is made.
    a_overlap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_busy) |-> (advance && last_word))
        else $error("transaction accepted in the middle of a run");

    // The last word of a run appears in the output register flagged as last.
    a_last_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && last_word) |=> (o_out_valid && o_out_item.last_of_run))
        else $error("last word of a run not flagged");

    // A draw with a nonzero count starts a run.
    a_draw_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in_item.req_type == REQ_DRAW) && (i_in_item.draw_count != 7'd0))
        |=> r_busy)
        else $error("draw transaction did not start a run");

    // A stalled output freezes the generator during a run.
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && o_out_valid && !i_out_ready) |=> ($stable(r_wnext) && $stable(r_mix[3])))
        else $error("generator advanced while output stalled");

endmodule
